// ===== hw/rtl/cbs_pkg.sv =====
// ---------------------------------------------------------------------------
// cylinder billiard step package
// shared widths, codes, types, elaboration-time cordic gain functions and saturation
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package cbs_pkg;

   localparam int DATA_W      = 32;
   localparam int REG_W       = 31;
   localparam int CSR_IDX_W   = 2;
   localparam int MUL_W       = 33;
   localparam int PROD_W      = 66;
   localparam int ACC_W       = 72;
   localparam int CORD_W      = 44;
   localparam int SPLIT       = 22;
   localparam int COEF_W      = 23;
   localparam int GUARD       = 8;
   localparam int COMP_SHIFT  = 30;
   localparam int SHIFT_W     = 5;

   localparam int CORDIC_STEPS_DEF = 16;
   localparam int FRAC_BITS_DEF    = 16;

   localparam logic [CSR_IDX_W-1:0] REG_RADIUS    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LENGTH    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_TIME_STEP = 2'd2;

   localparam logic [REG_W-1:0] RADIUS_RST    = 31'd65536;
   localparam logic [REG_W-1:0] LENGTH_RST    = 31'd65536;
   localparam logic [REG_W-1:0] TIME_STEP_RST = 31'd655;

   typedef enum logic [3:0] {
      S_IDLE, S_MV_MUL, S_MV_ADD, S_ZTEST, S_SQ_MUL, S_SQ_ACC, S_VEC, S_VFWD,
      S_VBACK, S_VC_MUL, S_VC_ACC, S_PBACK, S_PC_MUL, S_PC_ACC, S_DONE
   } state_type;

   typedef struct packed {
      logic               cw;
      logic [SHIFT_W-1:0] shift;
   } rot_ctrl_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] x;
      logic signed [DATA_W-1:0] y;
      logic signed [DATA_W-1:0] z;
      logic signed [DATA_W-1:0] vx;
      logic signed [DATA_W-1:0] vy;
      logic signed [DATA_W-1:0] vz;
      logic [DATA_W-1:0]        wall;
      logic [DATA_W-1:0]        ends;
   } result_type;

   // gain squared in q30, truncated per step
   function automatic logic [63:0] cordic_gain(input int steps);
      logic [63:0] g;
      int k;
      g = 64'd1 << 30;
      for (k = 0; k < steps; k++) begin
         g = g + (g >> (2 * k));
      end
      return g;
   endfunction

   // reciprocal of gain squared in q22, restoring division
   function automatic logic [COEF_W-1:0] inv_gain_sq(input int steps);
      logic [63:0] g;
      logic [63:0] rem;
      logic [63:0] q;
      int k;
      g   = cordic_gain(steps);
      rem = '0;
      q   = '0;
      for (k = 52; k >= 0; k--) begin
         rem = {rem[62:0], (k == 52) ? 1'b1 : 1'b0};
         if (rem >= g) begin
            rem  = rem - g;
            q[k] = 1'b1;
         end
      end
      return q[COEF_W-1:0];
   endfunction

   // reciprocal gain in q22 as integer square root
   function automatic logic [COEF_W-1:0] inv_gain(input int steps);
      logic [63:0] v;
      logic [63:0] r;
      logic [63:0] b;
      int k;
      v = 64'(inv_gain_sq(steps)) << 22;
      r = '0;
      b = 64'd1 << 62;
      for (k = 0; k < 32; k++) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r[COEF_W-1:0];
   endfunction

   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] hi;
      logic signed [ACC_W-1:0] lo;
      hi = ACC_W'(64'sh7FFFFFFF);
      lo = -ACC_W'(64'sh80000000);
      if (v > hi) begin
         return 32'sh7FFFFFFF;
      end else if (v < lo) begin
         return 32'sh80000000;
      end
      return v[DATA_W-1:0];
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/cbs_ifs.sv =====
// ---------------------------------------------------------------------------
// cylinder billiard step channels
// request, response and register write channels with valid/ready
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface cbs_req_if;
   logic        valid;
   logic        ready;
   logic        op;
   logic signed [31:0] init_x;
   logic signed [31:0] init_y;
   logic signed [31:0] init_z;
   logic signed [31:0] init_vx;
   logic signed [31:0] init_vy;
   logic signed [31:0] init_vz;
   modport source(output valid, op, init_x, init_y, init_z, init_vx, init_vy, init_vz,
                  input ready);
   modport sink(input valid, op, init_x, init_y, init_z, init_vx, init_vy, init_vz,
                output ready);
endinterface

interface cbs_rsp_if;
   logic        valid;
   logic        ready;
   logic signed [31:0] out_x;
   logic signed [31:0] out_y;
   logic signed [31:0] out_z;
   logic signed [31:0] out_vx;
   logic signed [31:0] out_vy;
   logic signed [31:0] out_vz;
   logic [31:0] wall_hits;
   logic [31:0] end_hits;
   modport source(output valid, out_x, out_y, out_z, out_vx, out_vy, out_vz, wall_hits,
                  end_hits, input ready);
   modport sink(input valid, out_x, out_y, out_z, out_vx, out_vy, out_vz, wall_hits,
                end_hits, output ready);
endinterface

interface cbs_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [30:0] data;
   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/cbs_rotator.sv =====
// ---------------------------------------------------------------------------
// cordic micro-rotation
// one shared shift-and-add rotation step, direction and shift chosen per cycle
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module cbs_rotator (
   input  wire logic signed [cbs_pkg::CORD_W-1:0] a,
   input  wire logic signed [cbs_pkg::CORD_W-1:0] b,
   input  wire cbs_pkg::rot_ctrl_type             ctrl,
   output logic signed [cbs_pkg::CORD_W-1:0]      a_out,
   output logic signed [cbs_pkg::CORD_W-1:0]      b_out
);
   logic signed [cbs_pkg::CORD_W-1:0] da;
   logic signed [cbs_pkg::CORD_W-1:0] db;

   always_comb begin
      da = b >>> ctrl.shift;
      db = a >>> ctrl.shift;
      if (ctrl.cw) begin
         a_out = a + da;
         b_out = b - db;
      end else begin
         a_out = a - da;
         b_out = b + db;
      end
   end
endmodule
`default_nettype wire

// ===== hw/rtl/cbs_mult.sv =====
// ---------------------------------------------------------------------------
// shared multiplier
// signed multiply with registered product
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module cbs_mult (
   input  wire logic                                clock,
   input  wire logic signed [cbs_pkg::MUL_W-1:0]    op_a,
   input  wire logic signed [cbs_pkg::MUL_W-1:0]    op_b,
   output logic signed [cbs_pkg::PROD_W-1:0]        prod_ff
);
   logic signed [cbs_pkg::PROD_W-1:0] prod_in;

   assign prod_in = cbs_pkg::PROD_W'(op_a) * cbs_pkg::PROD_W'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end
endmodule
`default_nettype wire

// ===== hw/rtl/cylinder_billiard_step.sv =====
// ---------------------------------------------------------------------------
// cylinder billiard step
// advances one particle in a closed cylinder with end cap and wall reflection
// ---------------------------------------------------------------------------
// A load word sets the particle state. A step word moves the particle and,
// when it crosses the curved wall, also reflects it: one shared cordic
// rotator runs the vectoring pass, the forward and backward velocity
// passes and the position pass one iteration a cycle, and one shared
// registered multiplier does the moves, squares and gain corrections.
// One word is in work at a time; the result is held in an output register
// while the next word is taken.
`timescale 1ns / 1ps
`default_nettype none
module cylinder_billiard_step #(
   parameter int CORDIC_STEPS = cbs_pkg::CORDIC_STEPS_DEF,
   parameter int FRAC_BITS    = cbs_pkg::FRAC_BITS_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   cbs_req_if.sink    req_ch,
   cbs_rsp_if.source  rsp_ch,
   cbs_csr_if.sink    csr_ch
);
   localparam int STEP_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
   localparam int AW = cbs_pkg::ACC_W;
   localparam int CW = cbs_pkg::CORD_W;
   localparam int MW = cbs_pkg::MUL_W;
   localparam logic [cbs_pkg::COEF_W-1:0] IK2 = cbs_pkg::inv_gain_sq(CORDIC_STEPS);
   localparam logic [cbs_pkg::COEF_W-1:0] IK  = cbs_pkg::inv_gain(CORDIC_STEPS);
   localparam logic signed [AW-1:0] MV_HALF   = AW'(1) <<< (FRAC_BITS - 1);
   localparam logic signed [AW-1:0] CMP_HALF  = AW'(1) <<< (cbs_pkg::COMP_SHIFT - 1);
   localparam logic [STEP_W-1:0]    STEP_LAST = STEP_W'(CORDIC_STEPS - 1);

   cbs_pkg::state_type state_ff, state_in;
   logic [1:0]              cnt_ff, cnt_in;
   logic [STEP_W-1:0]       step_ff, step_in;
   logic [CORDIC_STEPS-1:0] dir_ff, dir_in;
   logic                    flip_ff, flip_in;
   logic signed [31:0] px_ff, px_in, py_ff, py_in, pz_ff, pz_in;
   logic signed [31:0] vx_ff, vx_in, vy_ff, vy_in, vz_ff, vz_in;
   logic [31:0]        wall_ff, wall_in, end_ff, end_in;
   logic [30:0]        rad_ff, rad_in, len_ff, len_in, ts_ff, ts_in;
   logic signed [CW-1:0] ca_ff, ca_in, cb_ff, cb_in;
   logic signed [AW-1:0] acc_ff, acc_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   cbs_pkg::result_type  rsp_data_ff, rsp_data_in;

   logic signed [MW-1:0] mul_a, mul_b;
   logic signed [cbs_pkg::PROD_W-1:0] prod;
   cbs_pkg::rot_ctrl_type rot_ctrl;
   logic signed [CW-1:0] rot_a, rot_b;
   logic signed [AW-1:0] prod_x, mv_d, mv_sum, cmp_full;
   logic signed [31:0]   cmp_res, cmp_neg;
   logic signed [31:0]   mv_p, mv_v;
   logic signed [CW-1:0] src;
   logic                 req_take, rsp_free, wall_hit, z_hit;

   cbs_mult u_mult (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .prod_ff (prod)
   );

   cbs_rotator u_rot (
      .a     (ca_ff),
      .b     (cb_ff),
      .ctrl  (rot_ctrl),
      .a_out (rot_a),
      .b_out (rot_b)
   );

   assign req_ch.ready = (state_ff == cbs_pkg::S_IDLE);
   assign csr_ch.ready = 1'b1;
   assign req_take     = req_ch.valid && req_ch.ready;
   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.out_x     = rsp_data_ff.x;
   assign rsp_ch.out_y     = rsp_data_ff.y;
   assign rsp_ch.out_z     = rsp_data_ff.z;
   assign rsp_ch.out_vx    = rsp_data_ff.vx;
   assign rsp_ch.out_vy    = rsp_data_ff.vy;
   assign rsp_ch.out_vz    = rsp_data_ff.vz;
   assign rsp_ch.wall_hits = rsp_data_ff.wall;
   assign rsp_ch.end_hits  = rsp_data_ff.ends;

   // shared arithmetic around the product
   always_comb begin
      prod_x   = AW'(prod);
      case (cnt_ff)
         2'd0:    begin mv_p = px_ff; mv_v = vx_ff; end
         2'd1:    begin mv_p = py_ff; mv_v = vy_ff; end
         default: begin mv_p = pz_ff; mv_v = vz_ff; end
      endcase
      mv_d     = (prod_x + MV_HALF) >>> FRAC_BITS;
      mv_sum   = AW'(mv_p) + mv_d;
      cmp_full = acc_ff + prod_x;
      cmp_res  = cbs_pkg::sat32((cmp_full + CMP_HALF) >>> cbs_pkg::COMP_SHIFT);
      cmp_neg  = flip_ff ? cbs_pkg::sat32(-AW'(cmp_res)) : cmp_res;
      wall_hit = acc_ff > prod_x;
      z_hit    = (pz_ff <= 32'sd0) || (pz_ff > $signed({1'b0, len_ff}));
      src      = cnt_ff[1] ? cb_ff : ca_ff;
   end

   // multiplier operands and rotator control
   always_comb begin
      mul_a    = '0;
      mul_b    = '0;
      rot_ctrl = '{cw: 1'b0, shift: cbs_pkg::SHIFT_W'(step_ff)};
      case (state_ff)
         cbs_pkg::S_MV_MUL: begin
            mul_a = MW'(mv_v);
            mul_b = MW'(ts_ff);
         end
         cbs_pkg::S_SQ_MUL: begin
            case (cnt_ff)
               2'd0:    begin mul_a = MW'(px_ff); mul_b = MW'(px_ff); end
               2'd1:    begin mul_a = MW'(py_ff); mul_b = MW'(py_ff); end
               default: begin mul_a = MW'(rad_ff); mul_b = MW'(rad_ff); end
            endcase
         end
         cbs_pkg::S_VC_MUL, cbs_pkg::S_PC_MUL: begin
            mul_a = cnt_ff[0] ? MW'(src[cbs_pkg::SPLIT-1:0])
                              : MW'($signed(src[CW-1:cbs_pkg::SPLIT]));
            mul_b = (state_ff == cbs_pkg::S_VC_MUL) ? MW'(IK2) : MW'(IK);
         end
         cbs_pkg::S_VEC:   rot_ctrl.cw = ~cb_ff[CW-1];
         cbs_pkg::S_VFWD:  rot_ctrl.cw = dir_ff[step_ff];
         cbs_pkg::S_VBACK, cbs_pkg::S_PBACK: rot_ctrl.cw = ~dir_ff[step_ff];
         default: ;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cbs_pkg::S_IDLE:
            if (req_take) state_in = req_ch.op ? cbs_pkg::S_MV_MUL : cbs_pkg::S_DONE;
         cbs_pkg::S_MV_MUL: state_in = cbs_pkg::S_MV_ADD;
         cbs_pkg::S_MV_ADD:
            state_in = (cnt_ff == 2'd2) ? cbs_pkg::S_ZTEST : cbs_pkg::S_MV_MUL;
         cbs_pkg::S_ZTEST:  state_in = cbs_pkg::S_SQ_MUL;
         cbs_pkg::S_SQ_MUL: state_in = cbs_pkg::S_SQ_ACC;
         cbs_pkg::S_SQ_ACC: begin
            if (cnt_ff != 2'd2) state_in = cbs_pkg::S_SQ_MUL;
            else state_in = (acc_ff > prod_x) ? cbs_pkg::S_VEC : cbs_pkg::S_DONE;
         end
         cbs_pkg::S_VEC:    if (step_ff == STEP_LAST) state_in = cbs_pkg::S_VFWD;
         cbs_pkg::S_VFWD:   if (step_ff == STEP_LAST) state_in = cbs_pkg::S_VBACK;
         cbs_pkg::S_VBACK:  if (step_ff == '0) state_in = cbs_pkg::S_VC_MUL;
         cbs_pkg::S_VC_MUL: state_in = cbs_pkg::S_VC_ACC;
         cbs_pkg::S_VC_ACC:
            state_in = (cnt_ff == 2'd3) ? cbs_pkg::S_PBACK : cbs_pkg::S_VC_MUL;
         cbs_pkg::S_PBACK:  if (step_ff == '0) state_in = cbs_pkg::S_PC_MUL;
         cbs_pkg::S_PC_MUL: state_in = cbs_pkg::S_PC_ACC;
         cbs_pkg::S_PC_ACC:
            state_in = (cnt_ff == 2'd3) ? cbs_pkg::S_DONE : cbs_pkg::S_PC_MUL;
         cbs_pkg::S_DONE:   if (rsp_free) state_in = cbs_pkg::S_IDLE;
         default:           state_in = cbs_pkg::S_IDLE;
      endcase
   end

   // datapath updates
   always_comb begin
      cnt_in = cnt_ff;  step_in = step_ff;  dir_in = dir_ff;  flip_in = flip_ff;
      px_in = px_ff;  py_in = py_ff;  pz_in = pz_ff;
      vx_in = vx_ff;  vy_in = vy_ff;  vz_in = vz_ff;
      wall_in = wall_ff;  end_in = end_ff;
      rad_in = rad_ff;  len_in = len_ff;  ts_in = ts_ff;
      ca_in = ca_ff;  cb_in = cb_ff;  acc_in = acc_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;

      if (csr_ch.valid) begin
         case (csr_ch.index)
            cbs_pkg::REG_RADIUS:    rad_in = csr_ch.data;
            cbs_pkg::REG_LENGTH:    len_in = csr_ch.data;
            cbs_pkg::REG_TIME_STEP: ts_in  = csr_ch.data;
            default: ;
         endcase
      end

      case (state_ff)
         cbs_pkg::S_IDLE: begin
            cnt_in = 2'd0;
            if (req_take && !req_ch.op) begin
               px_in = req_ch.init_x;   py_in = req_ch.init_y;   pz_in = req_ch.init_z;
               vx_in = req_ch.init_vx;  vy_in = req_ch.init_vy;  vz_in = req_ch.init_vz;
               wall_in = '0;
               end_in  = '0;
            end
         end
         cbs_pkg::S_MV_ADD: begin
            case (cnt_ff)
               2'd0:    px_in = cbs_pkg::sat32(mv_sum);
               2'd1:    py_in = cbs_pkg::sat32(mv_sum);
               default: pz_in = cbs_pkg::sat32(mv_sum);
            endcase
            cnt_in = (cnt_ff == 2'd2) ? 2'd0 : cnt_ff + 2'd1;
         end
         cbs_pkg::S_ZTEST: begin
            if (z_hit) begin
               vz_in  = (vz_ff == 32'sh80000000) ? 32'sh7FFFFFFF : -vz_ff;
               end_in = (end_ff == '1) ? end_ff : end_ff + 32'd1;
            end
         end
         cbs_pkg::S_SQ_ACC: begin
            case (cnt_ff)
               2'd0:    acc_in = prod_x;
               2'd1:    acc_in = cmp_full;
               default: ;
            endcase
            cnt_in  = (cnt_ff == 2'd2) ? 2'd0 : cnt_ff + 2'd1;
            flip_in = px_ff[31];
            step_in = '0;
            ca_in   = px_ff[31] ? -CW'(px_ff) : CW'(px_ff);
            cb_in   = px_ff[31] ? -CW'(py_ff) : CW'(py_ff);
            if (cnt_ff == 2'd2 && !wall_hit) begin
               flip_in = flip_ff;
            end
         end
         cbs_pkg::S_VEC: begin
            dir_in[step_ff] = ~cb_ff[CW-1];
            if (step_ff == STEP_LAST) begin
               ca_in   = CW'(vx_ff) <<< cbs_pkg::GUARD;
               cb_in   = CW'(vy_ff) <<< cbs_pkg::GUARD;
               step_in = '0;
            end else begin
               ca_in   = rot_a;
               cb_in   = rot_b;
               step_in = step_ff + 1'b1;
            end
         end
         cbs_pkg::S_VFWD: begin
            cb_in = rot_b;
            if (step_ff == STEP_LAST) begin
               ca_in = -rot_a;
            end else begin
               ca_in   = rot_a;
               step_in = step_ff + 1'b1;
            end
         end
         cbs_pkg::S_VBACK, cbs_pkg::S_PBACK: begin
            ca_in  = rot_a;
            cb_in  = rot_b;
            cnt_in = 2'd0;
            if (step_ff != '0) step_in = step_ff - 1'b1;
         end
         cbs_pkg::S_VC_ACC, cbs_pkg::S_PC_ACC: begin
            cnt_in = cnt_ff + 2'd1;
            if (!cnt_ff[0]) begin
               acc_in = prod_x <<< cbs_pkg::SPLIT;
            end else if (state_ff == cbs_pkg::S_VC_ACC) begin
               if (cnt_ff[1]) vy_in = cmp_res;
               else vx_in = cmp_res;
            end else begin
               if (cnt_ff[1]) py_in = cmp_neg;
               else px_in = cmp_neg;
            end
            if (cnt_ff == 2'd3) begin
               if (state_ff == cbs_pkg::S_VC_ACC) begin
                  ca_in   = CW'(rad_ff) <<< cbs_pkg::GUARD;
                  cb_in   = '0;
                  step_in = STEP_LAST;
               end else begin
                  wall_in = (wall_ff == '1) ? wall_ff : wall_ff + 32'd1;
               end
            end
         end
         cbs_pkg::S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{x: px_ff, y: py_ff, z: pz_ff, vx: vx_ff, vy: vy_ff,
                                vz: vz_ff, wall: wall_ff, ends: end_ff};
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cbs_pkg::S_IDLE;
         cnt_ff       <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         px_ff <= '0;  py_ff <= '0;  pz_ff <= '0;
         vx_ff <= '0;  vy_ff <= '0;  vz_ff <= '0;
         wall_ff <= '0;
         end_ff  <= '0;
         rad_ff  <= cbs_pkg::RADIUS_RST;
         len_ff  <= cbs_pkg::LENGTH_RST;
         ts_ff   <= cbs_pkg::TIME_STEP_RST;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         px_ff <= px_in;  py_ff <= py_in;  pz_ff <= pz_in;
         vx_ff <= vx_in;  vy_ff <= vy_in;  vz_ff <= vz_in;
         wall_ff <= wall_in;
         end_ff  <= end_in;
         rad_ff  <= rad_in;
         len_ff  <= len_in;
         ts_ff   <= ts_in;
      end
   end

   always_ff @(posedge clock) begin
      dir_ff      <= dir_in;
      flip_ff     <= flip_in;
      ca_ff       <= ca_in;
      cb_ff       <= cb_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
   end
endmodule
`default_nettype wire
